// ===== src/mexp_pkg.sv =====
// Package for the modular exponentiation block: widths, reset value, state codes
// and the request/response structs between the sequencer and the multiplier.
// No dependencies.
`default_nettype none
package mexp_pkg;

  localparam int MOD_W    = 32;
  localparam int BASE_W   = 63;
  localparam int EXP_W    = 63;
  localparam int EXP_BITS = 63;
  localparam int SER_W    = 64;
  localparam int CNT_W    = 7;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic [MOD_W-1:0] MOD_RESET = 32'd1000000007;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MUL    = 5'b00100,
    S_SQR    = 5'b01000,
    S_DONE   = 5'b10000
  } mexp_state_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] mult;
    logic [SER_W-1:0] ser;
    logic [CNT_W-1:0] nbits;
  } mexp_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] res;
  } mexp_rsp_t;

endpackage
`default_nettype wire

// ===== src/mexp_mulmod.sv =====
// Shared bit-serial modular multiplier: one serial operand bit per cycle, MSB first.
// Depends on mexp_pkg.
`default_nettype none
module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [MOD_W-1:0] m_i,
  input  wire mexp_req_t        req_i,
  output mexp_rsp_t             rsp_o
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] r_r, r_nxt;
  logic [MOD_W-1:0] a_r, a_nxt;
  logic [SER_W-1:0] ser_r, ser_nxt;

  logic [MOD_W+1:0] t;
  logic [MOD_W+2:0] d1, d2;
  logic [MOD_W-1:0] r_step;

  always_comb begin
    t  = {1'b0, r_r, 1'b0} + (ser_r[SER_W-1] ? {2'b00, a_r} : '0);
    d1 = {1'b0, t} - {3'b000, m_i};
    d2 = {1'b0, t} - {2'b00, m_i, 1'b0};
    if (!d2[MOD_W+2]) begin
      r_step = d2[MOD_W-1:0];
    end else if (!d1[MOD_W+2]) begin
      r_step = d1[MOD_W-1:0];
    end else begin
      r_step = t[MOD_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    ser_nxt  = ser_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req_i.nbits;
      r_nxt    = '0;
      a_nxt    = req_i.mult;
      ser_nxt  = req_i.ser;
    end else if (busy_r) begin
      r_nxt   = r_step;
      ser_nxt = {ser_r[SER_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    r_r   <= r_nxt;
    a_r   <= a_nxt;
    ser_r <= ser_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.res  = r_r;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n) req_i.start |=> busy_r)
    else $error("multiplier did not start on request");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> (r_r < m_i))
    else $error("multiplier result not reduced");
`endif

endmodule
`default_nettype wire

// ===== src/mexp_seq.sv =====
// Square-and-multiply sequencer: reduces the base, then walks the exponent from bit 0.
// Issues every product to mexp_mulmod. Depends on mexp_pkg.
`default_nettype none
module mexp_seq
  import mexp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [BASE_W-1:0] base_i,
  input  wire logic [EXP_W-1:0]  exp_i,
  input  wire logic [MOD_W-1:0]  m_i,
  input  wire logic              ready_i,
  output logic                   idle_o,
  output logic                   done_o,
  output logic [MOD_W-1:0]       result_o,
  output mexp_req_t              req_o,
  input  wire mexp_rsp_t         rsp_i
);

  mexp_state_t         state_r, state_nxt;
  mexp_req_t           req_r, req_nxt;
  logic [MOD_W-1:0]    acc_r, acc_nxt;
  logic [MOD_W-1:0]    sq_r, sq_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;

  function automatic mexp_req_t issue(input logic [MOD_W-1:0] x, input logic [MOD_W-1:0] y);
    mexp_req_t q;
    q.start = 1'b1;
    q.mult  = x;
    q.ser   = {y, {(SER_W-MOD_W){1'b0}}};
    q.nbits = CNT_W'(MOD_W);
    return q;
  endfunction

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    req_nxt.start = 1'b0;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    exp_nxt   = exp_r;
    done_o    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          exp_nxt = exp_i[EXP_BITS-1:0];
          if (m_i == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            acc_nxt       = (m_i == MOD_W'(1)) ? '0 : MOD_W'(1);
            req_nxt.start = 1'b1;
            req_nxt.mult  = MOD_W'(1);
            req_nxt.ser   = {base_i, {(SER_W-BASE_W){1'b0}}};
            req_nxt.nbits = CNT_W'(BASE_W);
            state_nxt     = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (rsp_i.done) begin
          sq_nxt = rsp_i.res;
          if (exp_r == '0) begin
            state_nxt = S_DONE;
          end else if (exp_r[0]) begin
            req_nxt   = issue(acc_r, rsp_i.res);
            state_nxt = S_MUL;
          end else begin
            req_nxt   = issue(rsp_i.res, rsp_i.res);
            state_nxt = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (rsp_i.done) begin
          acc_nxt = rsp_i.res;
          if ((exp_r >> 1) == '0) begin
            state_nxt = S_DONE;
          end else begin
            req_nxt   = issue(sq_r, sq_r);
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (rsp_i.done) begin
          sq_nxt  = rsp_i.res;
          exp_nxt = exp_r >> 1;
          if (exp_nxt[0]) begin
            req_nxt   = issue(acc_r, rsp_i.res);
            state_nxt = S_MUL;
          end else begin
            req_nxt   = issue(rsp_i.res, rsp_i.res);
            state_nxt = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (ready_i) begin
          done_o    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      req_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      req_r     <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
  end

  assign idle_o   = (state_r == S_IDLE);
  assign result_o = acc_r;
  assign req_o    = req_r;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n)
      rsp_i.done |-> (state_r == S_REDUCE || state_r == S_MUL || state_r == S_SQR))
    else $error("multiplier result arrived with no product pending");
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_SQR && m_i != '0) |-> (acc_r < m_i))
    else $error("running product not reduced");
`endif

endmodule
`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// Top level: base^exponent mod modulus, modulus register, output register.
// Depends on mexp_pkg, mexp_mulmod and mexp_seq.
//
//   channel  direction  handshake            payload
//   in_      request    in_tvalid/in_tready  base, exponent
//   out_     result     out_tvalid/out_tready power_mod
//   cfg_     write      cfg_wr_en            modulus
//
// Every modular product runs through one bit-serial multiplier.
// An item takes the base reduction plus one product per set exponent bit and
// one square per bit below the top set bit, then enters the output register;
// for exponent 0 only the base reduction runs.
// Synchronous active-low reset; modulus resets to 1000000007.
// in_tready is high only while idle; a finished result waits in the output register.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // base[62:0], exponent[125:63], zero pad
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // power_mod[31:0]
  input  wire logic                   cfg_wr_en,
  input  wire logic [MOD_W-1:0]       cfg_wr_data
);

  logic [MOD_W-1:0] mod_r;
  logic             out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] out_data_r, out_data_nxt;

  logic             seq_ready;
  logic             seq_idle;
  logic             seq_done;
  logic [MOD_W-1:0] seq_result;
  mexp_req_t        mm_req;
  mexp_rsp_t        mm_rsp;

  assign in_tready = seq_idle;
  assign seq_ready = !out_valid_r || out_tready;

  mexp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (in_tvalid && in_tready),
    .base_i   (in_tdata[BASE_W-1:0]),
    .exp_i    (in_tdata[BASE_W+EXP_W-1:BASE_W]),
    .m_i      (mod_r),
    .ready_i  (seq_ready),
    .idle_o   (seq_idle),
    .done_o   (seq_done),
    .result_o (seq_result),
    .req_o    (mm_req),
    .rsp_i    (mm_rsp)
  );

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .m_i   (mod_r),
    .req_i (mm_req),
    .rsp_o (mm_rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (seq_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = seq_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mod_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in progress");
`endif

endmodule
`default_nettype wire
